>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks used by the project checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/tea_pkg.sv
// ---------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and round helpers for the TEA cipher block.
// ---------------------------------------------------------------------------
package tea_pkg;

  localparam int WORD_W     = 32;
  localparam int KEY_WORDS  = 4;
  localparam int ROUNDS_DEF = 32;
  localparam int CFG_IDX_W  = 8;

  localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

  // direction codes
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 8'd3;

  typedef logic [WORD_W-1:0]                 word_t;
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0]  key_t;

  // one item in flight along the cell row
  typedef struct packed {
    logic  valid;
    logic  cmd;
    word_t y;
    word_t z;
  } stage_t;

  // delta * n mod 2^32, evaluated at elaboration only
  function automatic word_t round_sum(input int unsigned n);
    logic [2*WORD_W-1:0] p;
    p = {{WORD_W{1'b0}}, DELTA} * (2*WORD_W)'(n);
    return p[WORD_W-1:0];
  endfunction

  // TEA mixing function
  function automatic word_t tea_mix(input word_t x, input word_t sum,
                                    input word_t ka, input word_t kb);
    return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

endpackage

>>> hw/rtl/tea_if.sv
// ---------------------------------------------------------------------------
// TEA channel interfaces
// Block input, result output and key configuration channels.
// ---------------------------------------------------------------------------
interface tea_in_if;
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  tea_pkg::word_t       first_word;
  tea_pkg::word_t       second_word;

  modport source (output valid, cmd, first_word, second_word, input ready);
  modport sink   (input valid, cmd, first_word, second_word, output ready);
endinterface

interface tea_out_if;
  logic                 valid;
  logic                 ready;
  tea_pkg::word_t       first_result;
  tea_pkg::word_t       second_result;

  modport source (output valid, first_result, second_result, input ready);
  modport sink   (input valid, first_result, second_result, output ready);
endinterface

interface tea_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tea_pkg::CFG_IDX_W-1:0]     index;
  tea_pkg::word_t                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/tea_cell.sv
// ---------------------------------------------------------------------------
// tea_cell
// One half-round of TEA: updates one block word from the other and hands on.
// ---------------------------------------------------------------------------
module tea_cell #(
  parameter tea_pkg::word_t ENC_SUM    = tea_pkg::DELTA,
  parameter tea_pkg::word_t DEC_SUM    = tea_pkg::DELTA,
  parameter bit             FIRST_HALF = 1'b1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  tea_pkg::key_t   key,
  input  tea_pkg::stage_t din,
  output tea_pkg::stage_t dout
);

  logic           dec;
  logic           upd_y;
  tea_pkg::word_t src;
  tea_pkg::word_t dst;
  tea_pkg::word_t ka;
  tea_pkg::word_t kb;
  tea_pkg::word_t sum;
  tea_pkg::word_t mix;
  tea_pkg::word_t res;

  // enc: y from z, then z from y; dec runs the halves mirrored
  always_comb begin
    dec   = (din.cmd == tea_pkg::CMD_DECRYPT);
    upd_y = FIRST_HALF ? !dec : dec;
    src   = upd_y ? din.z : din.y;
    dst   = upd_y ? din.y : din.z;
    ka    = upd_y ? key[0] : key[2];
    kb    = upd_y ? key[1] : key[3];
    sum   = dec ? DEC_SUM : ENC_SUM;
    mix   = tea_pkg::tea_mix(src, sum, ka, kb);
    res   = dec ? (dst - mix) : (dst + mix);
  end

  // data words carry no reset; only the valid bit is cleared
  always_ff @(posedge clk) begin
    if (en) begin
      dout.cmd <= din.cmd;
      dout.y   <= upd_y ? res : din.y;
      dout.z   <= upd_y ? din.z : res;
    end
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
  end

endmodule

>>> hw/rtl/tea_obuf.sv
// ---------------------------------------------------------------------------
// tea_obuf
// Output register with a one-entry skid stage behind the cell row.
// ---------------------------------------------------------------------------
module tea_obuf (
  input  logic            clk,
  input  logic            rst,
  input  tea_pkg::stage_t din,
  input  logic            out_ready,
  output logic            adv,
  output tea_pkg::stage_t dout
);

  tea_pkg::stage_t skid;
  logic            take;

  assign adv  = !skid.valid;
  assign take = !dout.valid || out_ready;

  always_ff @(posedge clk) begin
    if (take) begin
      dout.cmd <= skid.valid ? skid.cmd : din.cmd;
      dout.y   <= skid.valid ? skid.y   : din.y;
      dout.z   <= skid.valid ? skid.z   : din.z;
    end else if (adv) begin
      skid.cmd <= din.cmd;
      skid.y   <= din.y;
      skid.z   <= din.z;
    end
    if (rst) begin
      dout.valid <= 1'b0;
      skid.valid <= 1'b0;
    end else if (take) begin
      dout.valid <= skid.valid || din.valid;
      skid.valid <= 1'b0;
    end else if (din.valid && adv) begin
      skid.valid <= 1'b1;
    end
  end

endmodule

>>> hw/rtl/tea_block_cipher.sv
// ---------------------------------------------------------------------------
// tea_block_cipher
// Pipelined TEA encrypt/decrypt, one 64-bit block per cycle unless stalled.
// ---------------------------------------------------------------------------
// Usage:
//   block  : input items {cmd, first_word, second_word}; cmd 0 encrypts,
//            cmd 1 decrypts. Taken when valid and ready are both high.
//   result : output items {first_result, second_result}, one per block,
//            in the order the blocks were taken.
//   cfg    : key writes, index 0..3 selects key_word0..3, other indexes
//            are dropped. Always ready. Write keys only while no block is
//            in flight; every stage reads the key registers directly.
//   Path:  2*ROUNDS cells of one half-round each (64 by default), then
//            the output register, from block accept to result valid.
//   Throughput: one block per cycle unless stalled; set by the row of
//            half-round cells, one mix and one 32-bit add/sub per cell.
//   Reset (rst, synchronous): clears all valid bits and key words to 0.
//   Stall: when result is held, one more item lands in the skid stage,
//            then block.ready drops and the whole row freezes until the
//            receiver takes the waiting result.
// ---------------------------------------------------------------------------
module tea_block_cipher #(
  parameter int ROUNDS = tea_pkg::ROUNDS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tea_in_if.sink    block,
  tea_out_if.source result,
  tea_cfg_if.sink   cfg
);

  localparam int NSTAGES = 2 * ROUNDS;

  tea_pkg::key_t   key;
  tea_pkg::stage_t chain [NSTAGES+1];
  tea_pkg::stage_t res_item;
  logic            adv;

  // key registers; config port never stalls
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        tea_pkg::REG_KEY_WORD0: key[0] <= cfg.data;
        tea_pkg::REG_KEY_WORD1: key[1] <= cfg.data;
        tea_pkg::REG_KEY_WORD2: key[2] <= cfg.data;
        tea_pkg::REG_KEY_WORD3: key[3] <= cfg.data;
        default: ;  // out-of-range index: write ignored
      endcase
    end
  end

  // row entry: the row shifts whenever the skid stage is free
  assign block.ready  = adv;
  assign chain[0].valid = block.valid && adv;
  assign chain[0].cmd   = block.cmd;
  assign chain[0].y     = block.first_word;
  assign chain[0].z     = block.second_word;

  // cell g does half (g % 2) of round (g / 2); sums are fixed per cell
  for (genvar g = 0; g < NSTAGES; g++) begin : g_cell
    localparam int RND = g / 2;
    tea_cell #(
      .ENC_SUM    (tea_pkg::round_sum(RND + 1)),
      .DEC_SUM    (tea_pkg::round_sum(ROUNDS - RND)),
      .FIRST_HALF ((g % 2) == 0)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .key  (key),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  tea_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .din       (chain[NSTAGES]),
    .out_ready (result.ready),
    .adv       (adv),
    .dout      (res_item)
  );

  assign result.valid         = res_item.valid;
  assign result.first_result  = res_item.y;
  assign result.second_result = res_item.z;

endmodule

>>> hw/rtl/tea_checker.sv
// ---------------------------------------------------------------------------
// tea_checker
// Port-level checks on the TEA cipher block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tea_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready
);

  // a result, once shown, stays until taken
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // input only backs up when a result is waiting at the port
  `ASSERT_IMP(a_stall_cause, clk, rst, !in_ready, out_valid)

  // key port never stalls
  `ASSERT_IMP(a_cfg_ready, clk, rst, 1'b1, cfg_ready)

  // reset empties the row, so no result right after it
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

endmodule

bind tea_block_cipher tea_checker u_tea_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (block.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .cfg_ready (cfg.ready)
);
